// ===== rtl/core/lfh_pkg.sv =====
// shared constants, types and helpers for the led fire heat engine
`timescale 1ns / 1ps
`default_nettype none

package lfh_pkg;

    localparam int MAX_CELLS = 256;
    localparam int ADDR_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int HEAT_W    = 8;

    localparam int OP_W      = 2;
    localparam int CELL_W    = 8;
    localparam int SPARK_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam int GAIN_W    = 9;

    localparam logic [OP_W-1:0] OP_COOL   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CELLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;

    localparam logic [8:0]        CELLS_RST  = 9'd60;
    localparam logic [7:0]        CHANCE_RST = 8'd120;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 9'd128;
    localparam logic [7:0]        CHANCE_MAX = 8'd200;

    localparam logic [HEAT_W-1:0] PAL_LO   = 8'd85;
    localparam logic [HEAT_W-1:0] PAL_HI   = 8'd170;
    localparam logic [HEAT_W-1:0] HEAT_MAX = 8'd255;

    localparam logic [9:0] DIV3_MUL = 10'd683;
    localparam int         DIV3_SH  = 11;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [HEAT_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_ctl_t;

    // floor(x / 3) for x up to 765
    function automatic logic [HEAT_W-1:0] div3(input logic [9:0] x);
        logic [20:0] p;
        begin
            p = 21'(x) * 21'(DIV3_MUL);
            return p[DIV3_SH +: HEAT_W];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lfh_if.sv =====
// handshake channel interfaces: item feed, pixel results, config writes
`timescale 1ns / 1ps
`default_nettype none

interface lfh_feed_if;
    logic                         valid;
    logic                         ready;
    logic [lfh_pkg::OP_W-1:0]     operation;
    logic [lfh_pkg::CELL_W-1:0]   cell_req;
    logic [7:0]                   amount;
    logic [7:0]                   ignite_roll;
    logic [lfh_pkg::SPARK_W-1:0]  spark_cell;
    logic [7:0]                   spark_heat;

    modport source (
        output valid, operation, cell_req, amount, ignite_roll, spark_cell, spark_heat,
        input  ready
    );
    modport sink (
        input  valid, operation, cell_req, amount, ignite_roll, spark_cell, spark_heat,
        output ready
    );
endinterface

interface lfh_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] heat_level;

    modport source (
        output valid, red, green, blue, heat_level,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, heat_level,
        output ready
    );
endinterface

interface lfh_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lfh_pkg::CFG_IDX_W-1:0]   index;
    logic [lfh_pkg::CFG_DAT_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/lfh_heat_ram.sv =====
// heat store: one-write one-read synchronous ram with per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none

module lfh_heat_ram (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lfh_pkg::ram_ctl_t           ctl,
    output logic [lfh_pkg::HEAT_W-1:0]       rdata
);
    import lfh_pkg::*;

    logic [HEAT_W-1:0]    mem [MAX_CELLS];
    logic [MAX_CELLS-1:0] valid_reg;
    logic [HEAT_W-1:0]    rd_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rd_reg <= mem[ctl.raddr];
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.we)
            begin
                valid_reg[ctl.waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[ctl.raddr];
        end
    end

    assign rdata = rvalid_reg ? rd_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/core/led_fire_heat_engine.sv =====
// top level of the led fire heat engine: sequencer, palette and scaling
`timescale 1ns / 1ps
`default_nettype none

// Keeps one heat byte per LED cell in a synchronous ram.
// feed: one word per operation (cool, commit, read, write) with its random
//   fields; accepted when valid and ready are high together.
// pixel: one word per read, holding scaled red/green/blue and raw heat.
// cfg: register writes (cell count, ignition chance, gain), always ready; the user
//   writes them only while no operation is in flight; the block does not enforce it.
// Steps per word: write is done on acceptance; cool reads, then modifies and writes back;
// read does a ram read, palette, gain scaling, plus any wait for the pixel side;
// commit, when n >= 3 cells are active, does one ram write per diffused cell with
// the next read overlapped, then a spark read and write; with fewer, only the spark.
// The single ram read port sets this sequencing.
// A read result waits in an output register; the next word is taken while it
// waits, and only a further read stalls until the pixel side takes it.
// Reset loads the default registers and marks every cell as zero heat.
module led_fire_heat_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lfh_feed_if.sink   feed,
    lfh_pixel_if.source pixel,
    lfh_cfg_if.sink    cfg
);
    import lfh_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COOL   = 3'd1;
    localparam logic [2:0] S_PAL    = 3'd2;
    localparam logic [2:0] S_OUT    = 3'd3;
    localparam logic [2:0] S_PRIME  = 3'd4;
    localparam logic [2:0] S_DIFF   = 3'd5;
    localparam logic [2:0] S_SPK_RD = 3'd6;
    localparam logic [2:0] S_SPK_WR = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [8:0]          cells_reg;
    logic [7:0]          chance_reg;
    logic [GAIN_W-1:0]   gain_reg;

    logic [ADDR_W-1:0]   cell_reg, cell_next;
    logic [7:0]          amount_reg, amount_next;
    logic [7:0]          roll_reg, roll_next;
    logic [SPARK_W-1:0]  spark_reg, spark_next;
    logic [7:0]          sheat_reg, sheat_next;
    logic                hit_reg, hit_next;
    logic [ADDR_W-1:0]   k_reg, k_next;
    logic [HEAT_W-1:0]   a1_reg, a1_next;

    logic [7:0]          pr_reg, pr_next;
    logic [7:0]          pg_reg, pg_next;
    logic [7:0]          pb_reg, pb_next;
    logic [7:0]          pt_reg, pt_next;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          red_reg, red_next;
    logic [7:0]          green_reg, green_next;
    logic [7:0]          blue_reg, blue_next;
    logic [7:0]          heat_reg, heat_next;

    ram_ctl_t            ram_ctl;
    logic [HEAT_W-1:0]   rdata;

    logic [CNT_W-1:0]    n_cnt;
    logic                feed_hit;
    logic                accept;
    logic [7:0]          chance_eff;
    logic [8:0]          spark_sum;
    logic                fire;

    function automatic logic [7:0] scale(input logic [7:0] c, input logic [GAIN_W-1:0] g);
        logic [16:0] p;
        begin
            p = 17'(c) * 17'(g);
            return (p[16:15] != 2'd0) ? HEAT_MAX : p[14:7];
        end
    endfunction

    lfh_heat_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ram_ctl),
        .rdata (rdata)
    );

    assign n_cnt      = (int'(cells_reg) > MAX_CELLS) ? CNT_W'(MAX_CELLS) : CNT_W'(cells_reg);
    assign feed_hit   = int'(feed.cell_req) < int'(n_cnt);
    assign accept     = feed.valid && feed.ready;
    assign chance_eff = (chance_reg > CHANCE_MAX) ? CHANCE_MAX : chance_reg;
    assign spark_sum  = {1'b0, rdata} + {1'b0, sheat_reg};
    assign fire       = (roll_reg < chance_eff) && (int'(spark_reg) < int'(n_cnt));

    assign feed.ready       = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign pixel.valid      = out_valid_reg;
    assign pixel.red        = red_reg;
    assign pixel.green      = green_reg;
    assign pixel.blue       = blue_reg;
    assign pixel.heat_level = heat_reg;

    always_comb
    begin
        state_next     = state_reg;
        cell_next      = cell_reg;
        amount_next    = amount_reg;
        roll_next      = roll_reg;
        spark_next     = spark_reg;
        sheat_next     = sheat_reg;
        hit_next       = hit_reg;
        k_next         = k_reg;
        a1_next        = a1_reg;
        pr_next        = pr_reg;
        pg_next        = pg_reg;
        pb_next        = pb_reg;
        pt_next        = pt_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        heat_next      = heat_reg;
        out_valid_next = out_valid_reg && !pixel.ready;
        ram_ctl.we     = 1'b0;
        ram_ctl.waddr  = cell_reg;
        ram_ctl.wdata  = '0;
        ram_ctl.raddr  = feed.cell_req;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cell_next   = feed.cell_req;
                    amount_next = feed.amount;
                    roll_next   = feed.ignite_roll;
                    spark_next  = feed.spark_cell;
                    sheat_next  = feed.spark_heat;
                    hit_next    = feed_hit;
                    case (feed.operation)
                        OP_COOL:
                        begin
                            state_next = S_COOL;
                        end
                        OP_READ:
                        begin
                            state_next = S_PAL;
                        end
                        OP_WRITE:
                        begin
                            ram_ctl.we    = feed_hit;
                            ram_ctl.waddr = feed.cell_req;
                            ram_ctl.wdata = feed.amount;
                        end
                        OP_COMMIT:
                        begin
                            if (int'(n_cnt) >= 3)
                            begin
                                ram_ctl.raddr = ADDR_W'(n_cnt - CNT_W'(2));
                                k_next        = ADDR_W'(n_cnt - CNT_W'(1));
                                state_next    = S_PRIME;
                            end
                            else
                            begin
                                state_next = S_SPK_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_COOL:
            begin
                ram_ctl.we    = hit_reg;
                ram_ctl.waddr = cell_reg;
                ram_ctl.wdata = (amount_reg >= rdata) ? '0 : rdata - amount_reg;
                state_next    = S_IDLE;
            end
            S_PAL:
            begin
                pt_next = rdata;
                pr_next = '0;
                pg_next = '0;
                pb_next = '0;
                if (!hit_reg)
                begin
                    pt_next = '0;
                end
                else if (rdata < PAL_LO)
                begin
                    pr_next = (rdata << 1) + rdata;
                end
                else if (rdata < PAL_HI)
                begin
                    pr_next = HEAT_MAX;
                    pg_next = ((rdata - PAL_LO) << 1) + (rdata - PAL_LO);
                end
                else
                begin
                    pr_next = HEAT_MAX;
                    pg_next = HEAT_MAX;
                    pb_next = ((rdata - PAL_HI) << 1) + (rdata - PAL_HI);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || pixel.ready)
                begin
                    red_next       = scale(pr_reg, gain_reg);
                    green_next     = scale(pg_reg, gain_reg);
                    blue_next      = scale(pb_reg, gain_reg);
                    heat_next      = pt_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_PRIME:
            begin
                a1_next       = rdata;
                ram_ctl.raddr = k_reg - ADDR_W'(2);
                state_next    = S_DIFF;
            end
            S_DIFF:
            begin
                ram_ctl.we    = 1'b1;
                ram_ctl.waddr = k_reg;
                ram_ctl.wdata = div3({2'b00, a1_reg} + {1'b0, rdata, 1'b0});
                ram_ctl.raddr = k_reg - ADDR_W'(3);
                a1_next       = rdata;
                k_next        = k_reg - ADDR_W'(1);
                if (k_reg == ADDR_W'(2))
                begin
                    state_next = S_SPK_RD;
                end
            end
            S_SPK_RD:
            begin
                ram_ctl.raddr = ADDR_W'(spark_reg);
                state_next    = S_SPK_WR;
            end
            S_SPK_WR:
            begin
                ram_ctl.we    = fire;
                ram_ctl.waddr = ADDR_W'(spark_reg);
                ram_ctl.wdata = spark_sum[8] ? HEAT_MAX : spark_sum[7:0];
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cells_reg     <= CELLS_RST;
            chance_reg    <= CHANCE_RST;
            gain_reg      <= GAIN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_CELLS:
                    begin
                        cells_reg <= cfg.data;
                    end
                    REG_CHANCE:
                    begin
                        chance_reg <= cfg.data[7:0];
                    end
                    REG_GAIN:
                    begin
                        gain_reg <= cfg.data;
                    end
                    default:
                    begin
                        cells_reg <= cells_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg   <= cell_next;
        amount_reg <= amount_next;
        roll_reg   <= roll_next;
        spark_reg  <= spark_next;
        sheat_reg  <= sheat_next;
        hit_reg    <= hit_next;
        k_reg      <= k_next;
        a1_reg     <= a1_next;
        pr_reg     <= pr_next;
        pg_reg     <= pg_next;
        pb_reg     <= pb_next;
        pt_reg     <= pt_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        heat_reg   <= heat_next;
    end

endmodule

`default_nettype wire

// ===== dv/led_fire_heat_engine_tb.sv =====
// self-checking testbench for the led fire heat engine with a heat column predictor
`timescale 1ns / 1ps

module led_fire_heat_engine_tb;
    import lfh_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 58;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CELL_W-1:0]  cell_req;
        logic [7:0]         amount;
        logic [7:0]         ignite_roll;
        logic [SPARK_W-1:0] spark_cell;
        logic [7:0]         spark_heat;
    } feed_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] heat_level;
    } pixel_word_t;

    class fire_scoreboard;
        logic [HEAT_W-1:0] heat [MAX_CELLS];
        logic [8:0]        cells;
        logic [7:0]        chance;
        logic [GAIN_W-1:0] gain;
        pixel_word_t       pending_pixels[$];
        int                mismatches;

        function new();
            cells      = CELLS_RST;
            chance     = CHANCE_RST;
            gain       = GAIN_RST;
            mismatches = 0;
            foreach (heat[i])
                heat[i] = '0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DAT_W-1:0] value);
            case (idx)
                REG_CELLS:  cells  = value;
                REG_CHANCE: chance = value[7:0];
                REG_GAIN:   gain   = value;
                default:    ;
            endcase
        endfunction

        function int active_cells();
            return (int'(cells) > MAX_CELLS) ? MAX_CELLS : int'(cells);
        endfunction

        function logic [7:0] scaled(input int c);
            int v;
            v = (c * int'(gain)) >>> 7;
            return (v > 255) ? 8'd255 : 8'(v);
        endfunction

        function void note_feed(input feed_word_t w);
            int                n;
            int                h;
            int                r;
            int                g;
            int                b;
            int                lim;
            logic [HEAT_W-1:0] prior [MAX_CELLS];
            pixel_word_t       px;
            n = active_cells();
            case (w.operation)
                OP_COOL:
                    if (int'(w.cell_req) < n)
                    begin
                        h = heat[w.cell_req];
                        heat[w.cell_req] = (int'(w.amount) >= h) ? 8'd0 : 8'(h - int'(w.amount));
                    end
                OP_WRITE:
                    if (int'(w.cell_req) < n)
                        heat[w.cell_req] = w.amount;
                OP_COMMIT:
                begin
                    prior = heat;
                    // diffusion uses the column as it stood before the pass
                    for (int k = 2; k < n; k++)
                        heat[k] = 8'((int'(prior[k-1]) + 2 * int'(prior[k-2])) / 3);
                    lim = (chance > CHANCE_MAX) ? int'(CHANCE_MAX) : int'(chance);
                    if (int'(w.ignite_roll) < lim && int'(w.spark_cell) < n)
                    begin
                        h = int'(heat[w.spark_cell]) + int'(w.spark_heat);
                        heat[w.spark_cell] = (h > 255) ? HEAT_MAX : 8'(h);
                    end
                end
                default:
                begin
                    px = '0;
                    if (int'(w.cell_req) < n)
                    begin
                        h = heat[w.cell_req];
                        r = 0;
                        g = 0;
                        b = 0;
                        if (h < int'(PAL_LO))
                            r = 3 * h;
                        else if (h < int'(PAL_HI))
                        begin
                            r = 255;
                            g = 3 * (h - int'(PAL_LO));
                        end
                        else
                        begin
                            r = 255;
                            g = 255;
                            b = 3 * (h - int'(PAL_HI));
                        end
                        px.red        = scaled(r);
                        px.green      = scaled(g);
                        px.blue       = scaled(b);
                        px.heat_level = 8'(h);
                    end
                    pending_pixels.push_back(px);
                end
            endcase
        endfunction

        function void flag(input string what, input int unsigned want, input int unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_pixel(input pixel_word_t got);
            pixel_word_t want;
            if (pending_pixels.size() == 0)
            begin
                flag("pixel word with none expected", 0, got);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.red !== want.red)
                flag("red", want.red, got.red);
            if (got.green !== want.green)
                flag("green", want.green, got.green);
            if (got.blue !== want.blue)
                flag("blue", want.blue, got.blue);
            if (got.heat_level !== want.heat_level)
                flag("heat_level", want.heat_level, got.heat_level);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lfh_feed_if  feed_bus ();
    lfh_pixel_if pixel_bus ();
    lfh_cfg_if   cfg_bus ();

    led_fire_heat_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (feed_bus),
        .pixel (pixel_bus),
        .cfg   (cfg_bus)
    );

    fire_scoreboard sb = new();
    bit             steady_flow = 1'b0;
    int             idle_cycles = 0;

    int phase_cells  [PHASES] = '{3, 256, 2, 0, 511, 1, 17, 8, 60, 300, 40, 5};
    int phase_chance [PHASES] = '{200, 0, 255, 201, 120, 100, 150, 199, 60, 180, 200, 128};
    int phase_gain   [PHASES] = '{256, 0, 511, 1, 300, 128, 64, 257, 200, 127, 255, 384};

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic feed_word_t make_word(input logic [OP_W-1:0] op, input int cell_idx,
                                             input int amount, input int roll,
                                             input int spark, input int sheat);
        feed_word_t w;
        w.operation   = op;
        w.cell_req    = 8'(cell_idx);
        w.amount      = 8'(amount);
        w.ignite_roll = 8'(roll);
        w.spark_cell  = SPARK_W'(spark);
        w.spark_heat  = 8'(sheat);
        return w;
    endfunction

    function automatic feed_word_t random_word();
        feed_word_t w;
        int         n;
        int         pick;
        n    = sb.active_cells();
        pick = $urandom_range(0, 99);
        if (pick < 30)
            w.operation = OP_WRITE;
        else if (pick < 60)
            w.operation = OP_READ;
        else if (pick < 82)
            w.operation = OP_COOL;
        else
            w.operation = OP_COMMIT;
        if (n > 0 && $urandom_range(0, 9) != 0)
            w.cell_req = 8'($urandom_range(0, n - 1));
        else
            w.cell_req = 8'($urandom_range(0, 255));
        if (w.operation == OP_COOL && $urandom_range(0, 1) == 0)
            w.amount = 8'($urandom_range(0, 40));
        else
            w.amount = 8'($urandom_range(0, 255));
        w.ignite_roll = 8'($urandom_range(0, 255));
        w.spark_cell  = SPARK_W'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0)
            w.spark_heat = 8'($urandom_range(0, 255));
        else
            w.spark_heat = 8'($urandom_range(160, 255));
        return w;
    endfunction

    // starts and ends at a falling edge
    task automatic send_word(input feed_word_t w);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            feed_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        feed_bus.valid       <= 1'b1;
        feed_bus.operation   <= w.operation;
        feed_bus.cell_req    <= w.cell_req;
        feed_bus.amount      <= w.amount;
        feed_bus.ignite_roll <= w.ignite_roll;
        feed_bus.spark_cell  <= w.spark_cell;
        feed_bus.spark_heat  <= w.spark_heat;
        do
            @(posedge clk);
        while (!feed_bus.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DAT_W'(value);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        sb.set_register(idx, CFG_DAT_W'(value));
        @(negedge clk);
    endtask

    task automatic apply_setting(input int cells, input int chance, input int gain);
        write_reg(REG_CELLS, cells);
        write_reg(REG_CHANCE, chance);
        write_reg(REG_GAIN, gain);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_pixels();
        while (sb.pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : pixel_sink
        int stall;
        pixel_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = steady_flow ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                pixel_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pixel_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pixel_bus.valid);
        end
    end

    always @(posedge clk)
    begin : monitor
        feed_word_t  seen_feed;
        pixel_word_t seen_pixel;
        bit          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (feed_bus.valid && feed_bus.ready)
            begin
                seen_feed.operation   = feed_bus.operation;
                seen_feed.cell_req    = feed_bus.cell_req;
                seen_feed.amount      = feed_bus.amount;
                seen_feed.ignite_roll = feed_bus.ignite_roll;
                seen_feed.spark_cell  = feed_bus.spark_cell;
                seen_feed.spark_heat  = feed_bus.spark_heat;
                sb.note_feed(seen_feed);
                moved = 1'b1;
            end
            if (pixel_bus.valid && pixel_bus.ready)
            begin
                seen_pixel.red        = pixel_bus.red;
                seen_pixel.green      = pixel_bus.green;
                seen_pixel.blue       = pixel_bus.blue;
                seen_pixel.heat_level = pixel_bus.heat_level;
                sb.check_pixel(seen_pixel);
                moved = 1'b1;
            end
            if (cfg_bus.valid && cfg_bus.ready)
                moved = 1'b1;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        feed_bus.valid       <= 1'b0;
        feed_bus.operation   <= OP_COOL;
        feed_bus.cell_req    <= '0;
        feed_bus.amount      <= '0;
        feed_bus.ignite_roll <= '0;
        feed_bus.spark_cell  <= '0;
        feed_bus.spark_heat  <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= REG_CELLS;
        cfg_bus.data         <= '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // palette bands and their edges under reset settings
        send_word(make_word(OP_READ, 0, 0, 0, 0, 0));
        send_word(make_word(OP_WRITE, 0, 255, 0, 0, 0));
        send_word(make_word(OP_READ, 0, 0, 0, 0, 0));
        send_word(make_word(OP_WRITE, 1, 84, 0, 0, 0));
        send_word(make_word(OP_READ, 1, 0, 0, 0, 0));
        send_word(make_word(OP_WRITE, 2, 85, 0, 0, 0));
        send_word(make_word(OP_READ, 2, 0, 0, 0, 0));
        send_word(make_word(OP_WRITE, 3, 169, 0, 0, 0));
        send_word(make_word(OP_READ, 3, 0, 0, 0, 0));
        send_word(make_word(OP_WRITE, 4, 170, 0, 0, 0));
        send_word(make_word(OP_READ, 4, 0, 0, 0, 0));
        // cooling, with a floor at zero
        send_word(make_word(OP_COOL, 0, 10, 0, 0, 0));
        send_word(make_word(OP_READ, 0, 0, 0, 0, 0));
        send_word(make_word(OP_COOL, 1, 255, 0, 0, 0));
        send_word(make_word(OP_READ, 1, 0, 0, 0, 0));
        // top active cell, then cells past the active count
        send_word(make_word(OP_WRITE, 59, 200, 0, 0, 0));
        send_word(make_word(OP_WRITE, 60, 77, 0, 0, 0));
        send_word(make_word(OP_READ, 60, 0, 0, 0, 0));
        send_word(make_word(OP_COOL, 255, 1, 0, 0, 0));
        send_word(make_word(OP_READ, 255, 0, 0, 0, 0));
        // spark on cell 7, a miss, and a capped spark
        send_word(make_word(OP_COMMIT, 0, 0, 0, 7, 254));
        send_word(make_word(OP_READ, 7, 0, 0, 0, 0));
        send_word(make_word(OP_COMMIT, 0, 0, 255, 0, 160));
        send_word(make_word(OP_COMMIT, 0, 0, 119, 0, 255));
        send_word(make_word(OP_READ, 0, 0, 0, 0, 0));
        send_word(make_word(OP_READ, 59, 0, 0, 0, 0));
        feed_bus.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            drain_pixels();
            repeat (SETTLE_CYCLES) @(negedge clk);
            apply_setting(phase_cells[p], phase_chance[p], phase_gain[p]);
            steady_flow = (p % 4 == 3);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                    steady_flow = !steady_flow;
                // sender holds off until every pixel is back
                if (p == 6 && i == PHASE_WORDS / 2)
                begin
                    feed_bus.valid <= 1'b0;
                    drain_pixels();
                    @(negedge clk);
                end
                send_word(random_word());
            end
            feed_bus.valid <= 1'b0;
        end

        drain_pixels();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
